/* rtl/wsfp_pkg.sv */
// ----------------------------------------------------------------------------
// wsfp_pkg
// Types and constants shared by the websocket frame parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfp_pkg;

	// result kinds
	localparam logic [1:0] KIND_HDR = 2'd0;
	localparam logic [1:0] KIND_PAY = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	// error codes
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_RSV_BITS = 3'd1;
	localparam logic [2:0] ERR_RSV_OP   = 3'd2;
	localparam logic [2:0] ERR_CTRL_FRAG = 3'd3;
	localparam logic [2:0] ERR_CTRL_LEN = 3'd4;

	// 7-bit length codes
	localparam logic [6:0] LEN7_EXT16   = 7'd126;
	localparam logic [6:0] LEN7_EXT64   = 7'd127;
	localparam logic [6:0] LEN7_CTRL_MAX = 7'd125;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam int TDATA_W = 120;
	localparam int TUSER_W = 2;

	// byte as classified by the front end
	typedef struct packed {
		logic [7:0] data;
		logic       rsv_bits;  // any of bits 6..4 set
		logic       op_rsv;    // opcode 3..7 or above 0xa
		logic       len_big;   // 7-bit length above 125
		logic       len_ext16;
		logic       len_ext64;
		logic       len_zero;  // 7-bit length is zero
	} cls_t;

	// one result word
	typedef struct packed {
		logic [63:0] frame_length;
		logic [31:0] mask_key;
		logic        masked_flag;
		logic [3:0]  frame_opcode;
		logic        fin_flag;
		logic        frame_end;
		logic        header_done;
		logic [7:0]  payload_byte;
		logic [2:0]  error_code;
		logic [1:0]  kind;
	} res_t;

endpackage

`default_nettype wire

/* rtl/wsfp_front.sv */
// ----------------------------------------------------------------------------
// wsfp_front
// Input stage: takes stream bytes and tags each with its header features.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfp_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire  [7:0]           in_data,
	output logic                 push,
	output wsfp_pkg::cls_t       push_cls,
	input  wire                  q_full
);
	import wsfp_pkg::*;

	logic valid_s1;
	cls_t cls_s1;
	cls_t cls_d;

	always_comb begin
		cls_d.data      = in_data;
		cls_d.rsv_bits  = (in_data[6:4] != 3'd0);
		cls_d.op_rsv    = in_data[3:0] inside {[4'd3:4'd7], [4'd11:4'd15]};
		cls_d.len_big   = (in_data[6:0] > LEN7_CTRL_MAX);
		cls_d.len_ext16 = (in_data[6:0] == LEN7_EXT16);
		cls_d.len_ext64 = (in_data[6:0] == LEN7_EXT64);
		cls_d.len_zero  = (in_data[6:0] == 7'd0);
	end

	assign push     = valid_s1 && !q_full;
	assign in_ready = !valid_s1 || !q_full;
	assign push_cls = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cls_s1 <= cls_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/wsfp_queue.sv */
// ----------------------------------------------------------------------------
// wsfp_queue
// Short flop-based fifo of classified bytes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfp_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  wsfp_pkg::cls_t       push_cls,
	output logic                 full,
	input  wire                  pop,
	output logic                 head_valid,
	output wsfp_pkg::cls_t       head_cls
);
	import wsfp_pkg::*;

	cls_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign full       = (count_q == QAW'(0) + (QAW+1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_cls   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cls;
		end
	end

endmodule

`default_nettype wire

/* rtl/wsfp_back.sv */
// ----------------------------------------------------------------------------
// wsfp_back
// Frame header state machine, payload counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfp_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  head_valid,
	input  wsfp_pkg::cls_t       head_cls,
	output logic                 pop,
	output logic                 out_valid,
	input  wire                  out_ready,
	output wsfp_pkg::res_t       out_res
);
	import wsfp_pkg::*;

	localparam logic [2:0] PH_HDR1  = 3'd0;
	localparam logic [2:0] PH_HDR2  = 3'd1;
	localparam logic [2:0] PH_EXT16 = 3'd2;
	localparam logic [2:0] PH_EXT64 = 3'd3;
	localparam logic [2:0] PH_KEY   = 3'd4;
	localparam logic [2:0] PH_BODY  = 3'd5;

	logic [2:0]  phase_q,  phase_d;
	logic [2:0]  cnt_q,    cnt_d;
	logic        fin_q,    fin_d;
	logic [3:0]  op_q,     op_d;
	logic        masked_q, masked_d;
	logic [63:0] len_q,    len_d;
	logic [31:0] key_q,    key_d;
	logic [63:0] rem_q,    rem_d;

	logic        out_valid_q;
	res_t        out_res_q;
	res_t        res_d;

	logic [7:0]  b;
	logic [2:0]  cnt_inc;
	logic [2:0]  cnt_need;
	logic [63:0] len_sh;

	assign b        = head_cls.data;
	assign cnt_inc  = cnt_q + 3'd1;
	// eight length bytes wrap the counter back to zero
	assign cnt_need = (phase_q == PH_EXT16) ? 3'd2 : 3'd0;
	assign len_sh   = {len_q[55:0], b};

	assign pop       = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		fin_d    = fin_q;
		op_d     = op_q;
		masked_d = masked_q;
		len_d    = len_q;
		key_d    = key_q;
		rem_d    = rem_q;

		res_d              = '0;
		res_d.kind         = KIND_HDR;
		res_d.error_code   = ERR_NONE;

		case (phase_q)
			PH_HDR2: begin
				masked_d = b[7];
				if (op_q[3] && head_cls.len_big) begin
					res_d.error_code = ERR_CTRL_LEN;
					phase_d = PH_HDR1;
				end else begin
					cnt_d = 3'd0;
					if (head_cls.len_ext64) begin
						len_d   = '0;
						phase_d = PH_EXT64;
					end else if (head_cls.len_ext16) begin
						len_d   = '0;
						phase_d = PH_EXT16;
					end else begin
						len_d = {57'd0, b[6:0]};
						if (b[7]) begin
							phase_d = PH_KEY;
						end else begin
							res_d.header_done = 1'b1;
							if (head_cls.len_zero) begin
								res_d.frame_end = 1'b1;
								phase_d = PH_HDR1;
							end else begin
								rem_d   = {57'd0, b[6:0]};
								phase_d = PH_BODY;
							end
						end
					end
				end
			end
			PH_EXT16, PH_EXT64: begin
				len_d = len_sh;
				cnt_d = cnt_inc;
				if (cnt_inc == cnt_need) begin
					cnt_d = 3'd0;
					if (masked_q) begin
						phase_d = PH_KEY;
					end else begin
						res_d.header_done = 1'b1;
						if (len_sh == 64'd0) begin
							res_d.frame_end = 1'b1;
							phase_d = PH_HDR1;
						end else begin
							rem_d   = len_sh;
							phase_d = PH_BODY;
						end
					end
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], b};
				cnt_d = cnt_inc;
				if (cnt_inc == 3'd4) begin
					cnt_d = 3'd0;
					res_d.header_done = 1'b1;
					if (len_q == 64'd0) begin
						res_d.frame_end = 1'b1;
						phase_d = PH_HDR1;
					end else begin
						rem_d   = len_q;
						phase_d = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				res_d.kind         = KIND_PAY;
				res_d.payload_byte = b;
				rem_d = rem_q - 64'd1;
				if (rem_q == 64'd1) begin
					res_d.frame_end = 1'b1;
					phase_d = PH_HDR1;
				end
			end
			default: begin
				// first header byte, also taken for unused phase codes
				fin_d    = b[7];
				op_d     = b[3:0];
				masked_d = 1'b0;
				key_d    = '0;
				len_d    = '0;
				rem_d    = '0;
				cnt_d    = 3'd0;
				if (head_cls.rsv_bits) begin
					res_d.error_code = ERR_RSV_BITS;
				end else if (head_cls.op_rsv) begin
					res_d.error_code = ERR_RSV_OP;
				end else if (b[3] && !b[7]) begin
					res_d.error_code = ERR_CTRL_FRAG;
				end
				phase_d = (res_d.error_code != ERR_NONE) ? PH_HDR1 : PH_HDR2;
			end
		endcase

		if (res_d.error_code != ERR_NONE) begin
			res_d.kind = KIND_ERR;
		end

		res_d.fin_flag     = fin_d;
		res_d.frame_opcode = op_d;
		res_d.masked_flag  = masked_d;
		res_d.mask_key     = key_d;
		res_d.frame_length = len_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR1;
			cnt_q       <= '0;
			fin_q       <= 1'b0;
			op_q        <= '0;
			masked_q    <= 1'b0;
			len_q       <= '0;
			key_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q  <= phase_d;
				cnt_q    <= cnt_d;
				fin_q    <= fin_d;
				op_q     <= op_d;
				masked_q <= masked_d;
				len_q    <= len_d;
				key_q    <= key_d;
				rem_q    <= rem_d;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_res_q <= res_d;
		end
	end

	// an error word always carries a nonzero code
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_res_q.kind == KIND_ERR) |-> (out_res_q.error_code != ERR_NONE))
		else $error("error word without error code");

	// payload byte field is zero outside payload words
	a_pay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_res_q.kind != KIND_PAY) |-> (out_res_q.payload_byte == 8'd0))
		else $error("payload byte set on non-payload word");

	// while in the body there are bytes left to count
	a_body_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> (rem_q != 64'd0))
		else $error("body phase with zero bytes remaining");

	// header end is only flagged on a header word
	a_hdone_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_res_q.header_done |-> (out_res_q.kind == KIND_HDR))
		else $error("header done on non-header word");

	// a popped word always lands in the output register
	a_pop_out: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("popped word lost");

endmodule

`default_nettype wire

/* rtl/websocket_frame_parser.sv */
// ----------------------------------------------------------------------------
// websocket_frame_parser
// Byte-serial websocket frame header parser with payload pass-through.
// ----------------------------------------------------------------------------
// usage:
//   s_* takes the raw stream, one byte per word in s_tdata[7:0]
//   m_* gives one result word per input byte: m_tuser is the kind
//   (header byte, payload byte, error), m_tlast marks frame end, and
//   m_tdata carries error code, payload byte and the current header fields
//   path: a byte accepted on s_* passes the front register, the queue and
//   the result register before it shows on m_*
//   throughput: one byte per cycle while m_tready stays high; the front
//   register, a four-entry queue and the parser state machine each move one word per clock
//   reset: parser waits for the first header byte with all fields zero
//   stall: when m_tready is low the result register holds; the queue keeps
//   filling and s_tready drops only once the queue and the front register
//   are both full
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_parser (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // in_byte
	output logic        m_tvalid,
	input  wire         m_tready,
	// error_code[2:0], payload_byte[10:3], header_done[11], fin_flag[12],
	// frame_opcode[16:13], masked_flag[17], mask_key[49:18],
	// frame_length[113:50], zero fill[119:114]
	output logic [wsfp_pkg::TDATA_W-1:0] m_tdata,
	output logic [wsfp_pkg::TUSER_W-1:0] m_tuser,   // kind
	output logic        m_tlast    // frame_end
);
	import wsfp_pkg::*;

	logic push;
	cls_t push_cls;
	logic q_full;
	logic pop;
	logic head_valid;
	cls_t head_cls;
	res_t res;

	wsfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (s_tdata),
		.push     (push),
		.push_cls (push_cls),
		.q_full   (q_full)
	);

	wsfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cls   (push_cls),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cls   (head_cls)
	);

	wsfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cls   (head_cls),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_res    (res)
	);

	assign m_tdata = {6'd0, res.frame_length, res.mask_key, res.masked_flag,
		res.frame_opcode, res.fin_flag, res.header_done, res.payload_byte,
		res.error_code};
	assign m_tuser = res.kind;
	assign m_tlast = res.frame_end;

endmodule

`default_nettype wire

/* tb/websocket_frame_parser_tb.sv */
// ----------------------------------------------------------------------------
// websocket_frame_parser_tb
// Drives a byte stream of good frames, bad headers and noise into the parser
// with random gaps and output stalls. Every result word is checked field by
// field against a cycle-free model of the header state machine.
// ----------------------------------------------------------------------------

module websocket_frame_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wsfp_pkg::*;

	localparam int N_BYTES     = 1850;
	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_MARK   = -1;

	localparam logic [3:0] OP_CONT     = 4'h0;
	localparam logic [3:0] OP_TEXT     = 4'h1;
	localparam logic [3:0] OP_BIN      = 4'h2;
	localparam logic [3:0] OP_RSV_DATA = 4'h3;
	localparam logic [3:0] OP_CLOSE    = 4'h8;
	localparam logic [3:0] OP_PING     = 4'h9;
	localparam logic [3:0] OP_PONG     = 4'hA;
	localparam logic [3:0] OP_RSV_CTRL = 4'hF;

	typedef enum logic [2:0] {
		PH_HDR1, PH_HDR2, PH_EXT16, PH_EXT64, PH_KEY, PH_BODY
	} phase_e;

	typedef struct packed {
		phase_e      phase;
		logic [2:0]  cnt;
		logic        fin;
		logic [3:0]  opcode;
		logic        masked;
		logic [63:0] len;
		logic [31:0] key;
		logic [63:0] remaining;
	} parser_st_t;

	typedef struct packed {
		parser_st_t st;
		res_t       res;
	} step_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'h00;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [119:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;

	int         stream_q[$];
	res_t       pending_results[$];
	parser_st_t plan_st = '0;
	parser_st_t frame_st = '0;
	int n_built = 0;
	int n_in_sent = 0;
	int n_in_taken = 0;
	int n_out_taken = 0;
	int n_out_seen = 0;
	int n_errors = 0;
	int idle_cycles = 0;
	int in_gap = 0;
	int in_calm = 0;
	int out_stall = 0;
	int out_calm = 0;

	always #10 clk = ~clk;

	websocket_frame_parser u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// one byte through the header state machine: next state and result word
	function automatic step_t parse_byte(parser_st_t st, logic [7:0] b);
		step_t      r;
		logic [6:0] len7;
		logic       length_done;
		logic       header_end;
		r.st = st;
		r.res = '0;
		len7 = b[6:0];
		length_done = 1'b0;
		header_end = 1'b0;
		case (st.phase)
			PH_HDR2: begin
				r.st.masked = b[7];
				if (st.opcode >= OP_CLOSE && len7 > LEN7_CTRL_MAX) begin
					r.res.error_code = ERR_CTRL_LEN;
					r.st.phase = PH_HDR1;
				end else if (len7 == LEN7_EXT64) begin
					r.st.cnt = 3'd0;
					r.st.len = '0;
					r.st.phase = PH_EXT64;
				end else if (len7 == LEN7_EXT16) begin
					r.st.cnt = 3'd0;
					r.st.len = '0;
					r.st.phase = PH_EXT16;
				end else begin
					r.st.len = 64'(len7);
					length_done = 1'b1;
				end
			end
			PH_EXT16, PH_EXT64: begin
				r.st.len = {st.len[55:0], b};
				r.st.cnt = st.cnt + 3'd1;
				// the count wraps to zero after the eighth byte of a long length
				if (r.st.cnt == ((st.phase == PH_EXT16) ? 3'd2 : 3'd0))
					length_done = 1'b1;
			end
			PH_KEY: begin
				r.st.key = {st.key[23:0], b};
				r.st.cnt = st.cnt + 3'd1;
				if (r.st.cnt == 3'd4) begin
					r.st.cnt = 3'd0;
					header_end = 1'b1;
				end
			end
			PH_BODY: begin
				r.res.kind = KIND_PAY;
				r.res.payload_byte = b;
				r.st.remaining = st.remaining - 64'd1;
				if (r.st.remaining == 64'd0) begin
					r.res.frame_end = 1'b1;
					r.st.phase = PH_HDR1;
				end
			end
			default: begin
				r.st.fin = b[7];
				r.st.opcode = b[3:0];
				r.st.masked = 1'b0;
				r.st.key = '0;
				r.st.len = '0;
				r.st.remaining = '0;
				r.st.cnt = 3'd0;
				if (b[6:4] != 3'd0)
					r.res.error_code = ERR_RSV_BITS;
				else if ((r.st.opcode > OP_BIN && r.st.opcode < OP_CLOSE) ||
						r.st.opcode > OP_PONG)
					r.res.error_code = ERR_RSV_OP;
				else if (r.st.opcode >= OP_CLOSE && !r.st.fin)
					r.res.error_code = ERR_CTRL_FRAG;
				r.st.phase = (r.res.error_code != ERR_NONE) ? PH_HDR1 : PH_HDR2;
			end
		endcase
		if (length_done) begin
			r.st.cnt = 3'd0;
			if (r.st.masked)
				r.st.phase = PH_KEY;
			else
				header_end = 1'b1;
		end
		if (header_end) begin
			r.res.header_done = 1'b1;
			if (r.st.len == 64'd0) begin
				r.res.frame_end = 1'b1;
				r.st.phase = PH_HDR1;
			end else begin
				r.st.remaining = r.st.len;
				r.st.phase = PH_BODY;
			end
		end
		if (r.res.error_code != ERR_NONE)
			r.res.kind = KIND_ERR;
		r.res.fin_flag = r.st.fin;
		r.res.frame_opcode = r.st.opcode;
		r.res.masked_flag = r.st.masked;
		r.res.mask_key = r.st.key;
		r.res.frame_length = r.st.len;
		return r;
	endfunction

	// random byte, but keeps extended lengths small so frames finish
	function automatic logic [7:0] safe_byte();
		if (plan_st.phase == PH_EXT16 && plan_st.cnt == 3'd0)
			return 8'($urandom_range(0, 1));
		if (plan_st.phase == PH_EXT64 && plan_st.cnt != 3'd7)
			return 8'h00;
		return 8'($urandom);
	endfunction

	task automatic put_byte(input logic [7:0] b);
		step_t s;
		stream_q.push_back(int'(b));
		s = parse_byte(plan_st, b);
		plan_st = s.st;
		n_built++;
	endtask

	// enc: 0 seven-bit length, 1 sixteen-bit, 2 sixty-four-bit
	task automatic put_frame(input logic fin, input logic [3:0] op, input logic masked,
			input int enc, input logic [63:0] len);
		put_byte({fin, 3'b000, op});
		if (plan_st.phase == PH_HDR2) begin
			if (enc == 1) begin
				put_byte({masked, LEN7_EXT16});
				put_byte(len[15:8]);
				put_byte(len[7:0]);
			end else if (enc == 2) begin
				put_byte({masked, LEN7_EXT64});
				for (int i = 7; i >= 0; i--)
					put_byte(len[i*8 +: 8]);
			end else begin
				put_byte({masked, len[6:0]});
			end
		end
		while (plan_st.phase != PH_HDR1)
			put_byte(safe_byte());
	endtask

	function automatic void check_field(string what, logic [63:0] want_v, logic [63:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want_v, got_v);
			n_errors++;
		end
	endfunction

	// sender: one byte per word, random gap after some of them
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && n_in_taken != n_in_sent) begin
				// word still waiting for the handshake
			end else if (in_gap > 0) begin
				s_tvalid <= 1'b0;
				in_gap--;
			end else if (stream_q.size() > 0 && stream_q[0] == HOLD_MARK) begin
				s_tvalid <= 1'b0;
				if (pending_results.size() == 0 && n_in_taken == n_in_sent)
					void'(stream_q.pop_front());
			end else if (stream_q.size() > 0) begin
				s_tdata <= 8'(stream_q.pop_front());
				s_tvalid <= 1'b1;
				n_in_sent++;
				if (in_calm > 0)
					in_calm--;
				else if ($urandom_range(0, 40) == 0)
					in_calm = $urandom_range(10, 60);
				else if ($urandom_range(0, 2) != 0)
					in_gap = $urandom_range(0, 18);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stall after some result words
	always @(negedge clk) begin
		if (arst_n) begin
			if (n_out_taken != n_out_seen) begin
				n_out_seen = n_out_taken;
				if (out_calm > 0)
					out_calm--;
				else if ($urandom_range(0, 40) == 0)
					out_calm = $urandom_range(10, 60);
				else if ($urandom_range(0, 2) != 0)
					out_stall = $urandom_range(0, 18);
			end
			if (out_stall > 0) begin
				m_tready <= 1'b0;
				out_stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		step_t s;
		res_t  want;
		logic  in_fire;
		logic  out_fire;
		if (arst_n) begin
			in_fire = s_tvalid && s_tready;
			out_fire = m_tvalid && m_tready;
			if (in_fire) begin
				s = parse_byte(frame_st, s_tdata);
				frame_st = s.st;
				pending_results.push_back(s.res);
				n_in_taken++;
			end
			if (out_fire) begin
				n_out_taken++;
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected word: expected none, got tuser %0h tdata %0h",
						$time, m_tuser, m_tdata);
					n_errors++;
				end else begin
					want = pending_results.pop_front();
					check_field("kind", want.kind, m_tuser);
					check_field("error_code", want.error_code, m_tdata[2:0]);
					check_field("payload_byte", want.payload_byte, m_tdata[10:3]);
					check_field("header_done", want.header_done, m_tdata[11]);
					check_field("frame_end", want.frame_end, m_tlast);
					check_field("fin_flag", want.fin_flag, m_tdata[12]);
					check_field("frame_opcode", want.frame_opcode, m_tdata[16:13]);
					check_field("masked_flag", want.masked_flag, m_tdata[17]);
					check_field("mask_key", want.mask_key, m_tdata[49:18]);
					check_field("frame_length", want.frame_length, m_tdata[113:50]);
				end
			end
			if (in_fire || out_fire)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
				$display("websocket_frame_parser_tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		int       sel;
		int       v;
		logic [3:0] op;
		logic       fin;
		int       enc;
		logic [63:0] len;

		// directed: each header error, every length encoding, masked zero length
		put_byte({1'b1, 3'b111, OP_TEXT});
		put_byte({1'b1, 3'b000, OP_RSV_CTRL});
		put_byte({1'b0, 3'b000, OP_RSV_DATA});
		put_byte({1'b0, 3'b000, OP_PING});
		put_byte({1'b1, 3'b000, OP_CLOSE});
		put_byte({1'b1, LEN7_EXT64});
		put_frame(1'b1, OP_TEXT, 1'b0, 0, 64'd0);
		put_frame(1'b1, OP_PONG, 1'b1, 0, 64'd0);
		put_frame(1'b0, OP_BIN, 1'b0, 1, 64'd2);
		put_frame(1'b1, OP_CONT, 1'b1, 2, 64'd1);
		put_frame(1'b1, OP_CLOSE, 1'b0, 0, 64'(LEN7_CTRL_MAX));
		stream_q.push_back(HOLD_MARK);

		while (n_built < N_BYTES) begin
			sel = $urandom_range(0, 99);
			if (sel < 72) begin
				v = $urandom_range(0, 5);
				op = (v < 3) ? OP_CONT + 4'(v) : OP_CLOSE + 4'(v - 3);
				fin = (op >= OP_CLOSE) ? 1'b1 : 1'($urandom);
				v = $urandom_range(0, 5);
				enc = (op >= OP_CLOSE || v < 4) ? 0 : v - 3;
				if (enc == 0)
					len = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 125))
						: 64'($urandom_range(0, 12));
				else
					len = 64'($urandom_range(0, 300));
				put_frame(fin, op, 1'($urandom), enc, len);
			end else if (sel < 84) begin
				v = $urandom_range(0, 3);
				if (v == 0) begin
					put_byte({1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom)});
				end else if (v == 1) begin
					v = $urandom_range(0, 9);
					op = (v < 5) ? OP_RSV_DATA + 4'(v) : OP_PONG + 4'(v - 4);
					put_byte({1'($urandom), 3'b000, op});
				end else if (v == 2) begin
					put_byte({1'b0, 3'b000, OP_CLOSE + 4'($urandom_range(0, 2))});
				end else begin
					put_byte({1'b1, 3'b000, OP_CLOSE + 4'($urandom_range(0, 2))});
					put_byte({1'($urandom), 7'($urandom_range(126, 127))});
				end
			end else if (sel < 96) begin
				repeat ($urandom_range(1, 6))
					put_byte(safe_byte());
				while (plan_st.phase != PH_HDR1)
					put_byte(safe_byte());
			end else begin
				stream_q.push_back(HOLD_MARK);
			end
		end

		// full-scale 64-bit length, left unfinished at the end of the run
		put_byte({1'b1, 3'b000, OP_BIN});
		put_byte({1'b1, LEN7_EXT64});
		repeat (8) put_byte(8'hFF);
		repeat (10) put_byte(8'($urandom));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (stream_q.size() > 0 || n_in_taken != n_in_sent || pending_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("websocket_frame_parser_tb: PASS");
		else
			$display("websocket_frame_parser_tb: FAIL");
		$finish;
	end

endmodule
